// ----- src/k_sorted_stream_sorter_defines.svh -----
// Assertion macros used by the sorter's top-level RTL file.
`ifndef K_SORTED_STREAM_SORTER_DEFINES_SVH
`define K_SORTED_STREAM_SORTER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define KSS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kss check failed");

// Next-cycle implication, disabled during reset
`define KSS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kss check failed");

`endif

// ----- src/kss_pkg.sv -----
// Shared types and constants of the nearly sorted stream sorter.
package kss_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int DIST_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;

   // Register byte addresses
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_ADDR_DISTANCE = 3'd0;

   localparam logic [DIST_WIDTH-1:0] DIST_RESET = 4'd1;

   // Per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic                  insert;
      logic                  pop;
      logic [DATA_WIDTH-1:0] new_value;
   } cell_ctrl_type;

endpackage

// ----- src/kss_cell.sv -----
// One cell of the ordered window chain: holds a value and its valid bit.
module kss_cell
   import kss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctrl_type         ctrl,
   input  logic [DATA_WIDTH-1:0] prev_value,
   input  logic                  prev_valid,
   input  logic                  prev_gt,
   input  logic [DATA_WIDTH-1:0] next_value,
   input  logic                  next_valid,
   output logic [DATA_WIDTH-1:0] value,
   output logic                  valid,
   output logic                  gt
);

   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic                  valid_ff, valid_in;

   // Empty cells or strictly larger values make way for the new value
   assign gt    = !valid_ff || (value_ff > ctrl.new_value);
   assign value = value_ff;
   assign valid = valid_ff;

   // Take the neighbour's value on a shift, or the new value at its place
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.insert && gt) begin
         if (prev_gt) begin
            value_in = prev_value;
            valid_in = prev_valid;
         end else begin
            value_in = ctrl.new_value;
            valid_in = 1'b1;
         end
      end else if (ctrl.pop) begin
         value_in = next_value;
         valid_in = next_valid;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

// ----- src/kss_chain.sv -----
// Row of window cells, kept in ascending order with the smallest in cell 0.
module kss_chain
   import kss_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctrl_type         ctrl,
   output logic [DATA_WIDTH-1:0] head_value,
   output logic [DEPTH-1:0]      cell_valid
);

   logic [DATA_WIDTH-1:0] cell_value [DEPTH];
   logic [DEPTH-1:0]      cell_gt;

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic [DATA_WIDTH-1:0] prev_value, next_value;
         logic                  prev_valid, prev_gt, next_valid;

         // Cell 0 has no left neighbour; the last cell shifts in an empty slot
         if (i == 0) begin : g_first
            assign prev_value = '0;
            assign prev_valid = 1'b0;
            assign prev_gt    = 1'b0;
         end else begin : g_mid
            assign prev_value = cell_value[i-1];
            assign prev_valid = cell_valid[i-1];
            assign prev_gt    = cell_gt[i-1];
         end
         if (i == DEPTH - 1) begin : g_last
            assign next_value = '0;
            assign next_valid = 1'b0;
         end else begin : g_inner
            assign next_value = cell_value[i+1];
            assign next_valid = cell_valid[i+1];
         end

         kss_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .prev_value (prev_value),
            .prev_valid (prev_valid),
            .prev_gt    (prev_gt),
            .next_value (next_value),
            .next_valid (next_valid),
            .value      (cell_value[i]),
            .valid      (cell_valid[i]),
            .gt         (cell_gt[i])
         );
      end
   endgenerate

   assign head_value = cell_value[0];

endmodule

// ----- src/k_sorted_stream_sorter.sv -----
// An accepted item enters the chain; results leave through a registered output, one per cycle unless rsp_tready stalls.
// No new item is accepted while the window is draining results; req_tready is high only when idle.
// The single-port cell chain either inserts a value or shifts out the minimum, never both at once.
// Each insertion or removal moves the whole row of cells together.
// Synchronous active-high reset empties the window and sets window_distance to 1.
// Top level of the nearly sorted stream sorter, with its control and register port.
`include "k_sorted_stream_sorter_defines.svh"

module k_sorted_stream_sorter
   import kss_pkg::*;
#(
   parameter int WINDOW_DEPTH = 16
)
(
   input  logic                      clock,
   input  logic                      reset,
   // Input stream
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [DATA_WIDTH-1:0]     req_tdata,   // [31:0] value
   input  logic                      req_tlast,   // end_of_list
   // Result stream
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [DATA_WIDTH-1:0]     rsp_tdata,   // [31:0] sorted_value
   output logic                      rsp_tlast,   // last_out
   // Register port
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   localparam int CW = $clog2(WINDOW_DEPTH + 1);
   localparam int KW = (CW > DIST_WIDTH) ? CW : DIST_WIDTH;
   localparam logic [KW-1:0] K_CAP = KW'(WINDOW_DEPTH - 1);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic                  state_ff, state_in;
   logic [CW-1:0]         fill_ff, fill_in;
   logic                  last_ff, last_in;
   logic [DIST_WIDTH-1:0] dist_ff, dist_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   cell_ctrl_type         ctrl;
   logic [DATA_WIDTH-1:0] head_value;
   logic [WINDOW_DEPTH-1:0] cell_valid;

   logic [KW-1:0] dist_wide, k_eff, fill_wide, fill_inc, fill_dec;
   logic          accept, slot_free, pop, csr_write;

   // Register port: always ready, one register at the lowest address
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign dist_in    = (csr_write && csr_paddr == REG_ADDR_DISTANCE) ?
                       csr_pwdata[DIST_WIDTH-1:0] : dist_ff;
   assign csr_prdata = (csr_paddr == REG_ADDR_DISTANCE) ?
                       CSR_DATA_WIDTH'(dist_ff) : '0;

   // Effective distance, capped below the window capacity
   assign dist_wide = KW'(dist_ff);
   assign k_eff     = (dist_wide > K_CAP) ? K_CAP : dist_wide;
   assign fill_wide = KW'(fill_ff);
   assign fill_inc  = fill_wide + KW'(1);
   assign fill_dec  = fill_wide - KW'(1);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign pop        = (state_ff == ST_DRAIN) && slot_free;

   // Broadcast insert or pop to the chain
   always_comb begin
      ctrl.insert    = accept;
      ctrl.pop       = pop;
      ctrl.new_value = req_tdata;
   end

   // Sequence insertion, then the removals it causes
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               fill_in = CW'(fill_inc);
               last_in = req_tlast;
               if (req_tlast || fill_inc > k_eff) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (pop) begin
               fill_in      = CW'(fill_dec);
               rsp_valid_in = 1'b1;
               rsp_data_in  = head_value;
               rsp_last_in  = last_ff && (fill_dec == '0);
               if (last_ff ? (fill_dec == '0) : (fill_dec <= k_eff)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         last_ff      <= 1'b0;
         dist_ff      <= DIST_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         last_ff      <= last_in;
         dist_ff      <= dist_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   kss_chain #(
      .DEPTH (WINDOW_DEPTH)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .head_value (head_value),
      .cell_valid (cell_valid)
   );

   // Room for one more value whenever an item may be accepted
   `KSS_ASSERT_NOW(a_room_when_idle, clock, reset, state_ff == ST_IDLE, fill_wide <= K_CAP)
   // Occupied cells match the fill count
   `KSS_ASSERT_NOW(a_fill_matches, clock, reset, 1'b1, $countones(cell_valid) == fill_wide)
   // The head of the chain holds a value no larger than the one in cell 1
   `KSS_ASSERT_NOW(a_head_min, clock, reset, cell_valid[1], head_value <= u_chain.g_cell[1].u_cell.value)

endmodule
